// ===== hw/rtl/mld_pkg.sv =====
// ----------------------------------------------------------------------------
// Magic length deframer package
// Shared types and constants for the deframer: parse modes, header magic,
// size widths and the result record that moves between the pipeline stages.
// ----------------------------------------------------------------------------
`default_nettype none

package mld_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned SizeW  = 16;
  localparam int unsigned LimitW = 17;

  localparam logic [LimitW-1:0] LimitReset = 17'd32768;

  localparam logic [ByteW-1:0] MagicFirst  = 8'h59;
  localparam logic [ByteW-1:0] MagicSecond = 8'h4E;

  localparam logic [1:0] ModeHunt = 2'd0;
  localparam logic [1:0] ModeLen  = 2'd1;
  localparam logic [1:0] ModeBody = 2'd2;

  localparam logic [1:0] LenOrigLo = 2'd0;
  localparam logic [1:0] LenOrigHi = 2'd1;
  localparam logic [1:0] LenBodyLo = 2'd2;
  localparam logic [1:0] LenBodyHi = 2'd3;

  typedef struct packed {
    logic [ByteW-1:0] body_byte;
    logic             first_of_message;
    logic             last_of_message;
    logic             empty_message;
    logic [SizeW-1:0] original_length;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mld_in_reg.sv =====
// ----------------------------------------------------------------------------
// Deframer input register
// Holds one received byte until the parser consumes it. A new request is
// taken whenever the register is empty or is being drained in this cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mld_in_reg (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [mld_pkg::ByteW-1:0] rx_byte_i,
  input  wire logic                     take_i,
  output logic                          valid_o,
  output logic [mld_pkg::ByteW-1:0]     byte_o
);

  logic                      valid_q;
  logic                      valid_d;
  logic [mld_pkg::ByteW-1:0] byte_q;
  logic                      load;

  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;
  assign valid_d    = load || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= rx_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

`default_nettype wire

// ===== hw/rtl/mld_parser.sv =====
// ----------------------------------------------------------------------------
// Deframer parser
// Header hunt, length gathering and body pass-through. One byte is parsed
// per step and produces at most one result.
// ----------------------------------------------------------------------------
`default_nettype none

module mld_parser (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        step_i,
  input  wire logic [mld_pkg::ByteW-1:0]   byte_i,
  input  wire logic [mld_pkg::LimitW-1:0]  size_limit_i,
  output logic                             res_valid_o,
  output mld_pkg::result_t                 res_o
);

  logic [1:0]                mode_q, mode_d;
  logic [mld_pkg::ByteW-1:0] held_q, held_d;
  logic                      phase_q, phase_d;
  logic [1:0]                idx_q, idx_d;
  logic [mld_pkg::SizeW-1:0] orig_q, orig_d;
  logic [mld_pkg::SizeW-1:0] body_q, body_d;
  logic [mld_pkg::SizeW-1:0] rem_q, rem_d;
  logic                      hit;
  logic                      sizes_ok;
  logic                      is_last;

  assign sizes_ok = ({1'b0, body_d} < size_limit_i) && ({1'b0, orig_d} < size_limit_i);
  assign is_last  = (rem_q <= mld_pkg::SizeW'(1));

  always_comb begin
    mode_d  = mode_q;
    held_d  = held_q;
    phase_d = phase_q;
    idx_d   = idx_q;
    orig_d  = orig_q;
    body_d  = body_q;
    rem_d   = rem_q;
    hit     = 1'b0;
    res_o   = '0;
    res_o.original_length = orig_q;
    case (mode_q)
      mld_pkg::ModeLen: begin
        case (idx_q)
          mld_pkg::LenOrigLo: orig_d[7:0]  = byte_i;
          mld_pkg::LenOrigHi: orig_d[15:8] = byte_i;
          mld_pkg::LenBodyLo: body_d[7:0]  = byte_i;
          mld_pkg::LenBodyHi: body_d[15:8] = byte_i;
          default: ;
        endcase
        if (idx_q != mld_pkg::LenBodyHi) begin
          idx_d = idx_q + 2'd1;
        end else begin
          idx_d = mld_pkg::LenOrigLo;
          if (sizes_ok && body_d != '0) begin
            mode_d = mld_pkg::ModeBody;
            rem_d  = body_d;
          end else begin
            mode_d  = mld_pkg::ModeHunt;
            phase_d = 1'b0;
            if (sizes_ok) begin
              hit                   = 1'b1;
              res_o.last_of_message = 1'b1;
              res_o.empty_message   = 1'b1;
              res_o.original_length = orig_d;
            end
          end
        end
      end
      mld_pkg::ModeBody: begin
        hit                    = 1'b1;
        res_o.body_byte        = byte_i;
        res_o.first_of_message = (rem_q == body_q);
        res_o.last_of_message  = is_last;
        if (is_last) begin
          rem_d   = '0;
          mode_d  = mld_pkg::ModeHunt;
          phase_d = 1'b0;
          idx_d   = mld_pkg::LenOrigLo;
        end else begin
          rem_d = rem_q - mld_pkg::SizeW'(1);
        end
      end
      default: begin
        mode_d = mld_pkg::ModeHunt;
        if (!phase_q) begin
          held_d  = byte_i;
          phase_d = 1'b1;
        end else begin
          phase_d = 1'b0;
          if (held_q == mld_pkg::MagicFirst && byte_i == mld_pkg::MagicSecond) begin
            mode_d = mld_pkg::ModeLen;
            idx_d  = mld_pkg::LenOrigLo;
          end
        end
      end
    endcase
  end

  assign res_valid_o = step_i && hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= mld_pkg::ModeHunt;
      held_q  <= '0;
      phase_q <= 1'b0;
      idx_q   <= mld_pkg::LenOrigLo;
      orig_q  <= '0;
      body_q  <= '0;
      rem_q   <= '0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      held_q  <= held_d;
      phase_q <= phase_d;
      idx_q   <= idx_d;
      orig_q  <= orig_d;
      body_q  <= body_d;
      rem_q   <= rem_d;
    end
  end

`ifndef ASSERT_OFF
  // While a body is streaming there is always at least one byte left.
  a_body_rem_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == mld_pkg::ModeBody) |-> (rem_q != '0))
    else $error("body mode with no bytes remaining");

  // An empty message is a lone last marker with no data byte.
  a_empty_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.empty_message) |->
      (res_o.last_of_message && !res_o.first_of_message && res_o.body_byte == '0))
    else $error("malformed empty message result");

  // The last body byte sends the parser back to header hunting.
  a_last_to_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && mode_q == mld_pkg::ModeBody && is_last) |=>
      (mode_q == mld_pkg::ModeHunt && !phase_q))
    else $error("parser did not return to hunting after a body");

  // The length index only advances while gathering length bytes.
  a_idx_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q != mld_pkg::ModeLen) |-> (idx_q == mld_pkg::LenOrigLo))
    else $error("length index moved outside length gathering");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/mld_out_reg.sv =====
// ----------------------------------------------------------------------------
// Deframer result register
// Holds one result until the downstream side takes it. It can refill in the
// same cycle that its current result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module mld_out_reg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire mld_pkg::result_t  res_i,
  output logic                   free_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output mld_pkg::result_t       res_o
);

  logic             valid_q;
  logic             valid_d;
  mld_pkg::result_t res_q;

  assign free_o  = !valid_q || out_ready_i;
  assign valid_d = load_i || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

`ifndef ASSERT_OFF
  // A held result is never overwritten before it is taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> (!valid_q || out_ready_i))
    else $error("result register overwritten while full");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/magic_length_deframer.sv =====
// ----------------------------------------------------------------------------
// Magic length deframer
// Finds 'Y','N' headers in a byte stream, reads the original and body sizes,
// checks them against a size limit and passes on body bytes or an empty-message result.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake                Payload
//  -------  ---------  -----------------------  ---------------------------------
//  in       sink       in_valid_i / in_ready_o   rx_byte_i
//  out      source     out_valid_o / out_ready_i body_byte_o, first/last/empty,
//                                               original_length_o
//  cfg      sink       cfg_valid_i / cfg_ready_o size_limit_i
//
//  One byte is accepted per clock cycle when the result side keeps up.
//  A byte's result passes through the input register, then the result register.
//  Throughput is set by the single parse step between the two registers.
//  Reset clears all parse state and loads the size limit with 32768.
//  A stall on the result side holds the parser and then the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module magic_length_deframer (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [mld_pkg::ByteW-1:0]    rx_byte_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [mld_pkg::ByteW-1:0]         body_byte_o,
  output logic                              first_of_message_o,
  output logic                              last_of_message_o,
  output logic                              empty_message_o,
  output logic [mld_pkg::SizeW-1:0]         original_length_o,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [mld_pkg::LimitW-1:0]   size_limit_i
);

  logic [mld_pkg::LimitW-1:0] limit_q;
  logic                       byte_valid;
  logic [mld_pkg::ByteW-1:0]  byte_q;
  logic                       step;
  logic                       res_valid;
  logic                       out_free;
  mld_pkg::result_t           res;
  mld_pkg::result_t           res_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= mld_pkg::LimitReset;
    end else if (cfg_valid_i) begin
      limit_q <= size_limit_i;
    end
  end

  assign step = byte_valid && out_free;

  mld_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .rx_byte_i  (rx_byte_i),
    .take_i     (step),
    .valid_o    (byte_valid),
    .byte_o     (byte_q)
  );

  mld_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .byte_i       (byte_q),
    .size_limit_i (limit_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  mld_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_out)
  );

  assign body_byte_o        = res_out.body_byte;
  assign first_of_message_o = res_out.first_of_message;
  assign last_of_message_o  = res_out.last_of_message;
  assign empty_message_o    = res_out.empty_message;
  assign original_length_o  = res_out.original_length;

endmodule

`default_nettype wire
